// ===== hw/rtl/rmj_pkg.sv =====
package rmj_pkg;

   // pipeline geometry
   localparam int FRONT_STAGES = 3;
   localparam int ROOT_STEPS   = 32;
   localparam int PREP_STAGES  = 3;
   localparam int DIV_STEPS    = 32;
   localparam int PIPE_STAGES  = FRONT_STAGES + ROOT_STEPS + PREP_STAGES + DIV_STEPS;

   // input transaction
   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
   } req_type;

   // result transaction
   typedef struct packed {
      logic signed [31:0] range_by_px;
      logic signed [31:0] range_by_py;
      logic signed [31:0] bearing_by_px;
      logic signed [31:0] bearing_by_py;
      logic signed [31:0] rate_by_px;
      logic signed [31:0] rate_by_py;
      logic               range_zero;
   } rsp_type;

   // signs of the state and of the cross term, plus the zero range flag
   typedef struct packed {
      logic px_neg;
      logic py_neg;
      logic py_pos;
      logic c_neg;
      logic c_pos;
      logic zero;
   } sign_type;

   // data carried alongside the square root steps
   typedef struct packed {
      logic [31:0] apx;
      logic [31:0] apy;
      logic [63:0] ac;
      sign_type    sg;
   } side_type;

   // overflow flags, one per quotient lane: rx, ry, bx, by, tx, ty
   typedef struct packed {
      sign_type    sg;
      logic [5:0]  sat;
   } flag_type;

   localparam int LANE_RX = 0;
   localparam int LANE_RY = 1;
   localparam int LANE_BX = 2;
   localparam int LANE_BY = 3;
   localparam int LANE_TX = 4;
   localparam int LANE_TY = 5;

   localparam logic [31:0] POS_LIMIT = 32'h7fff_ffff;
   localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

   // clamp an unsigned quotient magnitude and apply the sign
   function automatic logic [31:0] sat_apply(logic [31:0] q, logic sat, logic neg);
      logic [31:0] lim;
      logic [31:0] m;
      lim = neg ? NEG_LIMIT : POS_LIMIT;
      m   = (sat || (q > lim)) ? lim : q;
      return neg ? (32'd0 - m) : m;
   endfunction

endpackage

// ===== hw/rtl/rmj_front.sv =====
module rmj_front (
   input  logic              clock,
   input  logic              adv,
   input  rmj_pkg::req_type  d,
   output logic [63:0]       s,
   output rmj_pkg::side_type side
);
   import rmj_pkg::*;

   logic signed [63:0] sqx_ff, sqx_in, sqy_ff, sqy_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [31:0]        apx1_ff, apx1_in, apy1_ff, apy1_in;
   logic               pxn1_ff, pxn1_in, pyn1_ff, pyn1_in, pyp1_ff, pyp1_in;
   logic [63:0]        s2_ff, s2_in;
   logic signed [64:0] c2_ff, c2_in;
   logic [31:0]        apx2_ff, apy2_ff;
   logic               pxn2_ff, pyn2_ff, pyp2_ff;
   logic [63:0]        s3_ff;
   side_type           side3_ff, side3_in;

   // stage 1: squares, cross products and magnitudes
   always_comb begin
      sqx_in  = d.pos_x * d.pos_x;
      sqy_in  = d.pos_y * d.pos_y;
      m1_in   = d.vel_x * d.pos_y;
      m2_in   = d.vel_y * d.pos_x;
      apx1_in = d.pos_x[31] ? (32'd0 - d.pos_x) : d.pos_x;
      apy1_in = d.pos_y[31] ? (32'd0 - d.pos_y) : d.pos_y;
      pxn1_in = d.pos_x[31];
      pyn1_in = d.pos_y[31];
      pyp1_in = !d.pos_y[31] && (d.pos_y != 32'sd0);
   end

   // stage 2: squared range and cross term
   always_comb begin
      s2_in = sqx_ff + sqy_ff;
      c2_in = m1_ff - m2_ff;
   end

   // stage 3: cross term magnitude and signs
   always_comb begin
      side3_in.apx   = apx2_ff;
      side3_in.apy   = apy2_ff;
      side3_in.ac    = c2_ff[64] ? 64'(-c2_ff) : c2_ff[63:0];
      side3_in.sg.px_neg = pxn2_ff;
      side3_in.sg.py_neg = pyn2_ff;
      side3_in.sg.py_pos = pyp2_ff;
      side3_in.sg.c_neg  = c2_ff[64];
      side3_in.sg.c_pos  = !c2_ff[64] && (c2_ff != 65'sd0);
      side3_in.sg.zero   = (s2_ff == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx_ff   <= sqx_in;
         sqy_ff   <= sqy_in;
         m1_ff    <= m1_in;
         m2_ff    <= m2_in;
         apx1_ff  <= apx1_in;
         apy1_ff  <= apy1_in;
         pxn1_ff  <= pxn1_in;
         pyn1_ff  <= pyn1_in;
         pyp1_ff  <= pyp1_in;
         s2_ff    <= s2_in;
         c2_ff    <= c2_in;
         apx2_ff  <= apx1_ff;
         apy2_ff  <= apy1_ff;
         pxn2_ff  <= pxn1_ff;
         pyn2_ff  <= pyn1_ff;
         pyp2_ff  <= pyp1_ff;
         s3_ff    <= s2_ff;
         side3_ff <= side3_in;
      end
   end

   assign s    = s3_ff;
   assign side = side3_ff;

endmodule

// ===== hw/rtl/rmj_sqrt_step.sv =====
module rmj_sqrt_step #(
   parameter int STEP = 0
) (
   input  logic        clock,
   input  logic        adv,
   input  logic [63:0] s_i,
   input  logic [35:0] rem_i,
   input  logic [31:0] root_i,
   output logic [63:0] s_o,
   output logic [35:0] rem_o,
   output logic [31:0] root_o
);
   localparam int PI = 2 * (31 - STEP);

   logic [35:0] rem_sh, trial;
   logic        ge;
   logic [63:0] s_ff;
   logic [35:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;

   // one root bit: bring down two radicand bits and try 4*root+1
   always_comb begin
      rem_sh  = {rem_i[33:0], s_i[PI+1:PI]};
      trial   = {2'b00, root_i, 2'b01};
      ge      = (rem_sh >= trial);
      rem_in  = ge ? (rem_sh - trial) : rem_sh;
      root_in = {root_i[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s_ff    <= s_i;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign s_o    = s_ff;
   assign rem_o  = rem_ff;
   assign root_o = root_ff;

endmodule

// ===== hw/rtl/rmj_prep.sv =====
module rmj_prep (
   input  logic              clock,
   input  logic              adv,
   input  logic [63:0]       s_i,
   input  logic [31:0]       r_i,
   input  rmj_pkg::side_type side_i,
   output logic [31:0]       r_o,
   output logic [63:0]       s_o,
   output logic [95:0]       dt_o,
   output logic [31:0]       rem_rx,
   output logic [31:0]       rem_ry,
   output logic [31:0]       nlo_rx,
   output logic [31:0]       nlo_ry,
   output logic [63:0]       rem_bx,
   output logic [63:0]       rem_by,
   output logic [95:0]       rem_tx,
   output logic [95:0]       rem_ty,
   output logic [31:0]       nlo_tx,
   output logic [31:0]       nlo_ty,
   output rmj_pkg::flag_type flag_o
);
   import rmj_pkg::*;

   // stage 1: partial products
   logic [63:0] pl_ff, pl_in, ph_ff, ph_in;
   logic [63:0] yl_ff, yl_in, yh_ff, yh_in, xl_ff, xl_in, xh_ff, xh_in;
   logic [31:0] r1_ff, apx1_ff, apy1_ff;
   logic [63:0] s1_ff;
   sign_type    sg1_ff;
   // stage 2: full products
   logic [95:0] d2_ff, d2_in, py2_ff, py2_in, px2_ff, px2_in;
   logic [31:0] r2_ff, apx2_ff, apy2_ff;
   logic [63:0] s2_ff;
   sign_type    sg2_ff;
   // stage 3: divider setup
   logic [31:0] r3_ff, rrx_ff, rrx_in, rry_ff, rry_in, nrx_ff, nrx_in, nry_ff, nry_in;
   logic [63:0] s3_ff, rbx_ff, rbx_in, rby_ff, rby_in;
   logic [95:0] d3_ff, rtx_ff, rtx_in, rty_ff, rty_in;
   logic [31:0] ntx_ff, ntx_in, nty_ff, nty_in;
   flag_type    flag3_ff, flag3_in;

   always_comb begin
      pl_in = s_i[31:0] * r_i;
      ph_in = s_i[63:32] * r_i;
      yl_in = side_i.apy * side_i.ac[31:0];
      yh_in = side_i.apy * side_i.ac[63:32];
      xl_in = side_i.apx * side_i.ac[31:0];
      xh_in = side_i.apx * side_i.ac[63:32];
   end

   always_comb begin
      d2_in  = {ph_ff, 32'd0} + {32'd0, pl_ff};
      py2_in = {yh_ff, 32'd0} + {32'd0, yl_ff};
      px2_in = {xh_ff, 32'd0} + {32'd0, xl_ff};
   end

   // high part of the numerator is the starting remainder; if it already
   // reaches the divisor the quotient cannot fit in 32 bits
   always_comb begin
      rrx_in = {16'd0, apx2_ff[31:16]};
      rry_in = {16'd0, apy2_ff[31:16]};
      nrx_in = {apx2_ff[15:0], 16'd0};
      nry_in = {apy2_ff[15:0], 16'd0};
      rbx_in = {32'd0, apy2_ff};
      rby_in = {32'd0, apx2_ff};
      rtx_in = {16'd0, py2_ff[95:16]};
      rty_in = {16'd0, px2_ff[95:16]};
      ntx_in = {py2_ff[15:0], 16'd0};
      nty_in = {px2_ff[15:0], 16'd0};
      flag3_in.sg           = sg2_ff;
      flag3_in.sat[LANE_RX] = (rrx_in >= r2_ff);
      flag3_in.sat[LANE_RY] = (rry_in >= r2_ff);
      flag3_in.sat[LANE_BX] = (rbx_in >= s2_ff);
      flag3_in.sat[LANE_BY] = (rby_in >= s2_ff);
      flag3_in.sat[LANE_TX] = (rtx_in >= d2_ff);
      flag3_in.sat[LANE_TY] = (rty_in >= d2_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pl_ff    <= pl_in;
         ph_ff    <= ph_in;
         yl_ff    <= yl_in;
         yh_ff    <= yh_in;
         xl_ff    <= xl_in;
         xh_ff    <= xh_in;
         r1_ff    <= r_i;
         s1_ff    <= s_i;
         apx1_ff  <= side_i.apx;
         apy1_ff  <= side_i.apy;
         sg1_ff   <= side_i.sg;
         d2_ff    <= d2_in;
         py2_ff   <= py2_in;
         px2_ff   <= px2_in;
         r2_ff    <= r1_ff;
         s2_ff    <= s1_ff;
         apx2_ff  <= apx1_ff;
         apy2_ff  <= apy1_ff;
         sg2_ff   <= sg1_ff;
         r3_ff    <= r2_ff;
         s3_ff    <= s2_ff;
         d3_ff    <= d2_ff;
         rrx_ff   <= rrx_in;
         rry_ff   <= rry_in;
         nrx_ff   <= nrx_in;
         nry_ff   <= nry_in;
         rbx_ff   <= rbx_in;
         rby_ff   <= rby_in;
         rtx_ff   <= rtx_in;
         rty_ff   <= rty_in;
         ntx_ff   <= ntx_in;
         nty_ff   <= nty_in;
         flag3_ff <= flag3_in;
      end
   end

   assign r_o    = r3_ff;
   assign s_o    = s3_ff;
   assign dt_o   = d3_ff;
   assign rem_rx = rrx_ff;
   assign rem_ry = rry_ff;
   assign nlo_rx = nrx_ff;
   assign nlo_ry = nry_ff;
   assign rem_bx = rbx_ff;
   assign rem_by = rby_ff;
   assign rem_tx = rtx_ff;
   assign rem_ty = rty_ff;
   assign nlo_tx = ntx_ff;
   assign nlo_ty = nty_ff;
   assign flag_o = flag3_ff;

endmodule

// ===== hw/rtl/rmj_div_step.sv =====
module rmj_div_step #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          adv,
   input  logic [DW-1:0] d_i,
   input  logic [DW-1:0] rem_i,
   input  logic [31:0]   nlo_i,
   input  logic [31:0]   q_i,
   output logic [DW-1:0] d_o,
   output logic [DW-1:0] rem_o,
   output logic [31:0]   nlo_o,
   output logic [31:0]   q_o
);
   logic [DW:0]   rem_sh, diff;
   logic          ge;
   logic [DW-1:0] d_ff, rem_ff, rem_in;
   logic [31:0]   nlo_ff, nlo_in, q_ff, q_in;

   // restoring division, one quotient bit
   always_comb begin
      rem_sh = {rem_i, nlo_i[31]};
      diff   = rem_sh - {1'b0, d_i};
      ge     = (rem_sh >= {1'b0, d_i});
      rem_in = ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      nlo_in = {nlo_i[30:0], 1'b0};
      q_in   = {q_i[30:0], ge};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_ff   <= d_i;
         rem_ff <= rem_in;
         nlo_ff <= nlo_in;
         q_ff   <= q_in;
      end
   end

   assign d_o   = d_ff;
   assign rem_o = rem_ff;
   assign nlo_o = nlo_ff;
   assign q_o   = q_ff;

endmodule

// ===== hw/rtl/radar_measurement_jacobian.sv =====
// Radar measurement Jacobian for an EKF with constant-velocity state.
// Input channel req_*: one transaction carries px, py, vx, vy in signed Q16.16.
// Result channel rsp_*: one transaction per input with the six distinct
// Jacobian entries in signed Q16.16 (saturated) and range_zero; when the
// squared range is zero all entries are zero and range_zero is set.
// Path: when the receiver keeps up, a result passes through 3 product/sum
// stages, 32 square root steps, 3 product stages, 32 division steps and the
// output register; the first stage loads at the accepting edge itself.
// Throughput: one transaction per cycle while the receiver keeps up; the pipeline is fully registered
// and every stage has its own valid bit.
// Stall: while rsp_valid is high and rsp_ready low the whole pipeline holds;
// a one-entry input buffer still takes one more transaction, after which
// req_ready drops until the result is taken.
// Reset (synchronous, active high) empties the pipeline and the input
// buffer; no results are pending afterward.
module radar_measurement_jacobian (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  rmj_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rmj_pkg::rsp_type rsp_data
);
   import rmj_pkg::*;

   logic     adv;
   logic     skid_valid_ff, skid_valid_in;
   req_type  skid_ff;
   logic     entry_valid;
   req_type  entry_data;
   logic [PIPE_STAGES-1:0] v_ff, v_in;
   logic     rsp_valid_ff;
   rsp_type  rsp_ff, rsp_in;

   // pipeline moves whenever the output register is free or being drained
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = !skid_valid_ff;

   always_comb begin
      entry_valid = skid_valid_ff || (req_valid && req_ready);
      entry_data  = skid_valid_ff ? skid_ff : req_data;
      skid_valid_in = skid_valid_ff;
      if (adv) begin
         skid_valid_in = 1'b0;
      end else if (req_valid && req_ready) begin
         skid_valid_in = 1'b1;
      end
      v_in = {v_ff[PIPE_STAGES-2:0], entry_valid};
   end

   always_ff @(posedge clock) begin
      if (!adv && req_valid && req_ready) begin
         skid_ff <= req_data;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         skid_valid_ff <= 1'b0;
         v_ff          <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         skid_valid_ff <= skid_valid_in;
         if (adv) begin
            v_ff         <= v_in;
            rsp_valid_ff <= v_ff[PIPE_STAGES-1];
         end
      end
   end

   // products and sums
   logic [63:0] front_s;
   side_type    front_side;

   rmj_front u_front (
      .clock (clock),
      .adv   (adv),
      .d     (entry_data),
      .s     (front_s),
      .side  (front_side)
   );

   // square root of the squared range, one bit per step
   logic [63:0] sq_s    [ROOT_STEPS+1];
   logic [35:0] sq_rem  [ROOT_STEPS+1];
   logic [31:0] sq_root [ROOT_STEPS+1];
   side_type    side_ff [ROOT_STEPS];

   assign sq_s[0]    = front_s;
   assign sq_rem[0]  = '0;
   assign sq_root[0] = '0;

   for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
      rmj_sqrt_step #(.STEP(j)) u_step (
         .clock  (clock),
         .adv    (adv),
         .s_i    (sq_s[j]),
         .rem_i  (sq_rem[j]),
         .root_i (sq_root[j]),
         .s_o    (sq_s[j+1]),
         .rem_o  (sq_rem[j+1]),
         .root_o (sq_root[j+1])
      );
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= front_side;
         for (int j = 1; j < ROOT_STEPS; j++) begin
            side_ff[j] <= side_ff[j-1];
         end
      end
   end

   // denominators, numerators and overflow checks
   logic [31:0] p_r, p_rem_rx, p_rem_ry, p_nlo_rx, p_nlo_ry, p_nlo_tx, p_nlo_ty;
   logic [63:0] p_s, p_rem_bx, p_rem_by;
   logic [95:0] p_dt, p_rem_tx, p_rem_ty;
   flag_type    p_flag;
   flag_type    flag_ff [DIV_STEPS];

   rmj_prep u_prep (
      .clock  (clock),
      .adv    (adv),
      .s_i    (sq_s[ROOT_STEPS]),
      .r_i    (sq_root[ROOT_STEPS]),
      .side_i (side_ff[ROOT_STEPS-1]),
      .r_o    (p_r),
      .s_o    (p_s),
      .dt_o   (p_dt),
      .rem_rx (p_rem_rx),
      .rem_ry (p_rem_ry),
      .nlo_rx (p_nlo_rx),
      .nlo_ry (p_nlo_ry),
      .rem_bx (p_rem_bx),
      .rem_by (p_rem_by),
      .rem_tx (p_rem_tx),
      .rem_ty (p_rem_ty),
      .nlo_tx (p_nlo_tx),
      .nlo_ty (p_nlo_ty),
      .flag_o (p_flag)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         flag_ff[0] <= p_flag;
         for (int j = 1; j < DIV_STEPS; j++) begin
            flag_ff[j] <= flag_ff[j-1];
         end
      end
   end

   // range lanes: position over range
   logic [31:0] ra_d [2][DIV_STEPS+1];
   logic [31:0] ra_r [2][DIV_STEPS+1];
   logic [31:0] ra_n [2][DIV_STEPS+1];
   logic [31:0] ra_q [2][DIV_STEPS+1];

   assign ra_d[0][0] = p_r;
   assign ra_r[0][0] = p_rem_rx;
   assign ra_n[0][0] = p_nlo_rx;
   assign ra_q[0][0] = '0;
   assign ra_d[1][0] = p_r;
   assign ra_r[1][0] = p_rem_ry;
   assign ra_n[1][0] = p_nlo_ry;
   assign ra_q[1][0] = '0;

   // bearing lanes: position over squared range
   logic [63:0] be_d [2][DIV_STEPS+1];
   logic [63:0] be_r [2][DIV_STEPS+1];
   logic [31:0] be_n [2][DIV_STEPS+1];
   logic [31:0] be_q [2][DIV_STEPS+1];

   assign be_d[0][0] = p_s;
   assign be_r[0][0] = p_rem_bx;
   assign be_n[0][0] = '0;
   assign be_q[0][0] = '0;
   assign be_d[1][0] = p_s;
   assign be_r[1][0] = p_rem_by;
   assign be_n[1][0] = '0;
   assign be_q[1][0] = '0;

   // range-rate lanes: position times cross term over range cubed
   logic [95:0] rt_d [2][DIV_STEPS+1];
   logic [95:0] rt_r [2][DIV_STEPS+1];
   logic [31:0] rt_n [2][DIV_STEPS+1];
   logic [31:0] rt_q [2][DIV_STEPS+1];

   assign rt_d[0][0] = p_dt;
   assign rt_r[0][0] = p_rem_tx;
   assign rt_n[0][0] = p_nlo_tx;
   assign rt_q[0][0] = '0;
   assign rt_d[1][0] = p_dt;
   assign rt_r[1][0] = p_rem_ty;
   assign rt_n[1][0] = p_nlo_ty;
   assign rt_q[1][0] = '0;

   for (genvar l = 0; l < 2; l++) begin : g_lane
      for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
         rmj_div_step #(.DW(32)) u_ra (
            .clock (clock), .adv (adv),
            .d_i   (ra_d[l][j]),   .rem_i (ra_r[l][j]),
            .nlo_i (ra_n[l][j]),   .q_i   (ra_q[l][j]),
            .d_o   (ra_d[l][j+1]), .rem_o (ra_r[l][j+1]),
            .nlo_o (ra_n[l][j+1]), .q_o   (ra_q[l][j+1])
         );
         rmj_div_step #(.DW(64)) u_be (
            .clock (clock), .adv (adv),
            .d_i   (be_d[l][j]),   .rem_i (be_r[l][j]),
            .nlo_i (be_n[l][j]),   .q_i   (be_q[l][j]),
            .d_o   (be_d[l][j+1]), .rem_o (be_r[l][j+1]),
            .nlo_o (be_n[l][j+1]), .q_o   (be_q[l][j+1])
         );
         rmj_div_step #(.DW(96)) u_rt (
            .clock (clock), .adv (adv),
            .d_i   (rt_d[l][j]),   .rem_i (rt_r[l][j]),
            .nlo_i (rt_n[l][j]),   .q_i   (rt_q[l][j]),
            .d_o   (rt_d[l][j+1]), .rem_o (rt_r[l][j+1]),
            .nlo_o (rt_n[l][j+1]), .q_o   (rt_q[l][j+1])
         );
      end
   end

   // output register: saturation, signs, zero range
   flag_type fl;

   always_comb begin
      fl = flag_ff[DIV_STEPS-1];
      rsp_in.range_by_px   = sat_apply(ra_q[0][DIV_STEPS], fl.sat[LANE_RX], fl.sg.px_neg);
      rsp_in.range_by_py   = sat_apply(ra_q[1][DIV_STEPS], fl.sat[LANE_RY], fl.sg.py_neg);
      rsp_in.bearing_by_px = sat_apply(be_q[0][DIV_STEPS], fl.sat[LANE_BX], fl.sg.py_pos);
      rsp_in.bearing_by_py = sat_apply(be_q[1][DIV_STEPS], fl.sat[LANE_BY], fl.sg.px_neg);
      rsp_in.rate_by_px    = sat_apply(rt_q[0][DIV_STEPS], fl.sat[LANE_TX],
                                       fl.sg.py_neg != fl.sg.c_neg);
      rsp_in.rate_by_py    = sat_apply(rt_q[1][DIV_STEPS], fl.sat[LANE_TY],
                                       fl.sg.px_neg != fl.sg.c_pos);
      rsp_in.range_zero    = fl.sg.zero;
      if (fl.sg.zero) begin
         rsp_in = '0;
         rsp_in.range_zero = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   // zero range forces every entry to zero
   a_zero_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.range_zero) |->
         (rsp_ff.range_by_px == 32'sd0) && (rsp_ff.range_by_py == 32'sd0) &&
         (rsp_ff.bearing_by_px == 32'sd0) && (rsp_ff.bearing_by_py == 32'sd0) &&
         (rsp_ff.rate_by_px == 32'sd0) && (rsp_ff.rate_by_py == 32'sd0))
      else $error("nonzero entry with zero range");

   // position over truncated range never exceeds one in magnitude
   a_range_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |->
         (rsp_ff.range_by_px <= 32'sd65536) && (rsp_ff.range_by_px >= -32'sd65536) &&
         (rsp_ff.range_by_py <= 32'sd65536) && (rsp_ff.range_by_py >= -32'sd65536))
      else $error("range term out of bounds");

   // the input buffer drains as soon as the pipeline moves
   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && adv) |=> (v_ff[0] && !skid_valid_ff))
      else $error("input buffer not drained");
`endif

endmodule
